### rtl/ssa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants for the sized slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int NUM_CLASSES    = 5;
    localparam int CNT_W          = 5;
    localparam int CLS_W          = 3;
    localparam int SIZE_W         = 3;
    localparam int SLOT_W         = 7;
    localparam int TAG_W          = 8;
    localparam int BASE_W         = 8;
    localparam int STATUS_W       = 3;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;
    localparam int DEF_MAX_SLOTS  = 16;
    localparam int DEF_WAIT_DEPTH = 16;

    localparam logic MODE_REQ = 1'b0;
    localparam logic MODE_REL = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_SEATED  = 3'd0,
        ST_WAITING = 3'd1,
        ST_HANDED  = 3'd2,
        ST_FREED   = 3'd3,
        ST_FULL    = 3'd4,
        ST_BAD     = 3'd5
    } t_status;

    typedef logic [NUM_CLASSES-1:0][CNT_W-1:0] t_counts;

    typedef struct packed {
        logic              kind;
        logic              bad;
        logic [CLS_W-1:0]  cls;
        logic [CNT_W-1:0]  idx;
        logic [BASE_W-1:0] base;
        logic [SLOT_W-1:0] id;
        logic [TAG_W-1:0]  tag;
    } t_job;

endpackage

### rtl/ssa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_cfg_regs
// APB register file holding the five class counts and their clamped values.
// ----------------------------------------------------------------------------
module ssa_cfg_regs #(
    parameter int MAX_SLOTS_PER_CLASS = ssa_pkg::DEF_MAX_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [ssa_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [ssa_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [ssa_pkg::APB_DATA_W-1:0] o_prdata,
    output logic                           o_pready,
    output ssa_pkg::t_counts               o_eff_counts
);
    import ssa_pkg::*;

    t_counts         r_cnt;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign reg_idx  = i_paddr[4:2];
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (wr_en) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (reg_idx == CLS_W'(k)) begin
                    r_cnt[k] <= i_pwdata[CNT_W-1:0];
                end
            end
        end
    end

    always_comb begin
        o_prdata = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (reg_idx == CLS_W'(k)) begin
                o_prdata = APB_DATA_W'(r_cnt[k]);
            end
        end
    end

    // counts above the per-class capacity behave as the capacity
    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if ({2'b00, r_cnt[k]} > 7'(MAX_SLOTS_PER_CLASS)) begin
                o_eff_counts[k] = CNT_W'(MAX_SLOTS_PER_CLASS);
            end else begin
                o_eff_counts[k] = r_cnt[k];
            end
        end
    end

endmodule

### rtl/ssa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_front
// Classifies incoming transfers: size class, slot base and release mapping.
// ----------------------------------------------------------------------------
module ssa_front (
    input  logic                        i_mode,
    input  logic [ssa_pkg::SIZE_W-1:0]  i_group_size,
    input  logic [ssa_pkg::SLOT_W-1:0]  i_slot_id,
    input  logic [ssa_pkg::TAG_W-1:0]   i_group_tag,
    input  ssa_pkg::t_counts            i_eff_counts,
    output ssa_pkg::t_job               o_job
);
    import ssa_pkg::*;

    logic [NUM_CLASSES-1:0][BASE_W-1:0] base;
    logic [BASE_W-1:0]                  rem;
    logic                               found;
    logic [CLS_W-1:0]                   rel_cls;
    logic [CNT_W-1:0]                   rel_idx;
    logic                               req_bad;
    logic [CLS_W-1:0]                   req_cls;

    always_comb begin
        base[0] = '0;
        for (int k = 1; k < NUM_CLASSES; k++) begin
            base[k] = base[k-1] + BASE_W'(i_eff_counts[k-1]);
        end
    end

    // release: walk the classes subtracting each count
    always_comb begin
        rem     = BASE_W'(i_slot_id);
        found   = 1'b0;
        rel_cls = '0;
        rel_idx = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (!found) begin
                if (rem < BASE_W'(i_eff_counts[k])) begin
                    found   = 1'b1;
                    rel_cls = CLS_W'(k);
                    rel_idx = rem[CNT_W-1:0];
                end else begin
                    rem = rem - BASE_W'(i_eff_counts[k]);
                end
            end
        end
    end

    always_comb begin
        req_bad = (i_group_size == '0) || (i_group_size > SIZE_W'(NUM_CLASSES));
        req_cls = req_bad ? '0 : i_group_size - 1'b1;
    end

    always_comb begin
        o_job.kind = i_mode;
        o_job.id   = i_slot_id;
        o_job.tag  = i_group_tag;
        if (i_mode == MODE_REQ) begin
            o_job.bad  = req_bad;
            o_job.cls  = req_cls;
            o_job.idx  = '0;
            o_job.base = base[req_cls];
        end else begin
            o_job.bad  = !found;
            o_job.cls  = rel_cls;
            o_job.idx  = rel_idx;
            o_job.base = '0;
        end
    end

endmodule

### rtl/ssa_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_job_queue
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module ssa_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ssa_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output ssa_pkg::t_job o_job
);
    import ssa_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_valid & o_ready;
    assign pop     = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/ssa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_back
// Executes jobs: slot maps, per-class wait FIFOs and the result register.
// ----------------------------------------------------------------------------
module ssa_back #(
    parameter int MAX_SLOTS_PER_CLASS = ssa_pkg::DEF_MAX_SLOTS,
    parameter int WAIT_DEPTH          = ssa_pkg::DEF_WAIT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssa_pkg::t_counts              i_eff_counts,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  ssa_pkg::t_job                 i_job,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ssa_pkg::STATUS_W-1:0]  o_status,
    output logic [ssa_pkg::SLOT_W-1:0]    o_granted_slot,
    output logic [ssa_pkg::TAG_W-1:0]     o_granted_tag
);
    import ssa_pkg::*;

    localparam int MS = MAX_SLOTS_PER_CLASS;
    localparam int PW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW = $clog2(WAIT_DEPTH + 1);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state                r_state,     n_state;
    logic [MS-1:0]         r_occ [NUM_CLASSES];
    logic [MS-1:0]         n_occ [NUM_CLASSES];
    logic [PW-1:0]         r_head [NUM_CLASSES];
    logic [PW-1:0]         n_head [NUM_CLASSES];
    logic [PW-1:0]         r_tail [NUM_CLASSES];
    logic [PW-1:0]         n_tail [NUM_CLASSES];
    logic [FW-1:0]         r_fill [NUM_CLASSES];
    logic [FW-1:0]         n_fill [NUM_CLASSES];
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [SLOT_W-1:0]     r_out_slot,  n_out_slot;
    logic [TAG_W-1:0]      r_out_tag,   n_out_tag;
    logic [SLOT_W-1:0]     r_rel_id,    n_rel_id;

    logic [TAG_W-1:0]      r_wq [NUM_CLASSES][WAIT_DEPTH];
    logic [TAG_W-1:0]      r_rd_data;
    logic                  wq_we;
    logic                  wq_re;
    logic [CLS_W-1:0]      cls;
    logic [MS-1:0]         cur_occ;
    logic [MS-1:0]         valid_mask;
    logic [MS-1:0]         free_bits;
    logic [MS-1:0]         first_free;
    logic [CNT_W-1:0]      free_idx;
    logic                  occ_bit;
    logic                  can_emit;
    logic                  take;
    logic [PW-1:0]         cur_head;
    logic [PW-1:0]         cur_tail;
    logic [FW-1:0]         cur_fill;

    assign cls      = i_job.cls;
    assign cur_occ  = r_occ[cls];
    assign cur_head = r_head[cls];
    assign cur_tail = r_tail[cls];
    assign cur_fill = r_fill[cls];
    assign can_emit = !r_out_valid || i_out_ready;
    assign o_job_ready = (r_state == S_IDLE) && can_emit;
    assign take     = i_job_valid && o_job_ready;

    always_comb begin
        for (int i = 0; i < MS; i++) begin
            valid_mask[i] = (7'(i) < {2'b00, i_eff_counts[cls]});
        end
        free_bits  = ~cur_occ & valid_mask;
        first_free = free_bits & (~free_bits + MS'(1));
        free_idx   = '0;
        for (int i = MS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = CNT_W'(i);
            end
        end
        occ_bit = |(cur_occ & (MS'(1) << i_job.idx));
    end

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == PW'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_tag    = r_out_tag;
        n_rel_id     = r_rel_id;
        wq_we        = 1'b0;
        wq_re        = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_out_valid = 1'b1;
                    if (i_job.bad) begin
                        n_out_status = ST_BAD;
                        n_out_slot   = '0;
                        n_out_tag    = '0;
                    end else if (i_job.kind == MODE_REQ) begin
                        n_out_tag = i_job.tag;
                        if (|free_bits) begin
                            n_occ[cls]   = cur_occ | first_free;
                            n_out_status = ST_SEATED;
                            n_out_slot   = SLOT_W'(i_job.base + BASE_W'(free_idx));
                        end else if (cur_fill == FW'(WAIT_DEPTH)) begin
                            n_out_status = ST_FULL;
                            n_out_slot   = '0;
                        end else begin
                            wq_we        = 1'b1;
                            n_tail[cls]  = ptr_next(cur_tail);
                            n_fill[cls]  = cur_fill + 1'b1;
                            n_out_status = ST_WAITING;
                            n_out_slot   = '0;
                        end
                    end else begin
                        if (!occ_bit) begin
                            n_out_status = ST_BAD;
                            n_out_slot   = '0;
                            n_out_tag    = '0;
                        end else if (cur_fill != '0) begin
                            wq_re       = 1'b1;
                            n_head[cls] = ptr_next(cur_head);
                            n_fill[cls] = cur_fill - 1'b1;
                            n_out_valid = 1'b0;
                            n_rel_id    = i_job.id;
                            n_state     = S_READ;
                        end else begin
                            n_occ[cls]   = cur_occ & ~(MS'(1) << i_job.idx);
                            n_out_status = ST_FREED;
                            n_out_slot   = i_job.id;
                            n_out_tag    = '0;
                        end
                    end
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_HANDED;
                n_out_slot   = r_rel_id;
                n_out_tag    = r_rd_data;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // wait-queue storage, registered read
    always_ff @(posedge i_clk) begin
        if (wq_we) begin
            r_wq[cls][cur_tail] <= i_job.tag;
        end
        if (wq_re) begin
            r_rd_data <= r_wq[cls][cur_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_occ[k]  <= '0;
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_occ       <= n_occ;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
        end
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_tag    <= n_out_tag;
        r_rel_id     <= n_rel_id;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_slot;
    assign o_granted_tag  = r_out_tag;

    a_read_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result register busy during queue read");

    a_read_hands_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && r_out_status == ST_HANDED
                                 && r_state == S_IDLE))
        else $error("queue read did not produce a handover");

    a_req_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_job.kind == MODE_REQ) |=> (r_out_valid && r_state == S_IDLE))
        else $error("request result missing");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= FW'(WAIT_DEPTH))
        else $error("wait queue overfilled");

endmodule

### rtl/sized_slot_allocator_with_wait_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sized_slot_allocator_with_wait_queue_unit
// Five-class slot allocator with per-class FIFO of waiting requesters.
// ----------------------------------------------------------------------------
// A request, a rejected item or a plain release is executed as it is accepted
// and its result is registered; a release that hands the slot to a waiter
// first passes through the S_READ state for the registered read of the
// wait-queue memory, and its result is registered after that. A two-entry job
// queue between the classifier and the executor keeps input transfers flowing
// while a result waits on the output. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sized_slot_allocator_with_wait_queue_unit #(
    parameter int MAX_SLOTS_PER_CLASS = ssa_pkg::DEF_MAX_SLOTS,
    parameter int WAIT_DEPTH          = ssa_pkg::DEF_WAIT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [2:0] group_size, [9:3] slot_id, [17:10] group_tag, [23:18] zero
    input  logic [23:0]                    i_s_axis_tdata,
    // [0] mode
    input  logic [0:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [6:0] granted_slot, [14:7] granted_tag, [15] zero
    output logic [15:0]                    o_m_axis_tdata,
    // [2:0] status
    output logic [2:0]                     o_m_axis_tuser,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [ssa_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [ssa_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [ssa_pkg::APB_DATA_W-1:0] o_prdata,
    output logic                           o_pready
);
    import ssa_pkg::*;

    t_counts            eff_counts;
    t_job               front_job;
    t_job               q_job;
    logic               q_valid;
    logic               q_ready;
    logic [SLOT_W-1:0]  granted_slot;
    logic [TAG_W-1:0]   granted_tag;

    ssa_cfg_regs #(
        .MAX_SLOTS_PER_CLASS (MAX_SLOTS_PER_CLASS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (i_psel),
        .i_penable    (i_penable),
        .i_pwrite     (i_pwrite),
        .i_paddr      (i_paddr),
        .i_pwdata     (i_pwdata),
        .o_prdata     (o_prdata),
        .o_pready     (o_pready),
        .o_eff_counts (eff_counts)
    );

    ssa_front u_front (
        .i_mode       (i_s_axis_tuser[0]),
        .i_group_size (i_s_axis_tdata[2:0]),
        .i_slot_id    (i_s_axis_tdata[9:3]),
        .i_group_tag  (i_s_axis_tdata[17:10]),
        .i_eff_counts (eff_counts),
        .o_job        (front_job)
    );

    ssa_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_job   (front_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    ssa_back #(
        .MAX_SLOTS_PER_CLASS (MAX_SLOTS_PER_CLASS),
        .WAIT_DEPTH          (WAIT_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_eff_counts   (eff_counts),
        .i_job_valid    (q_valid),
        .o_job_ready    (q_ready),
        .i_job          (q_job),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_status       (o_m_axis_tuser),
        .o_granted_slot (granted_slot),
        .o_granted_tag  (granted_tag)
    );

    assign o_m_axis_tdata = {1'b0, granted_tag, granted_slot};

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sized slot allocator. A scoreboard class keeps
// its own copy of the per-class slot maps and wait queues, predicts the
// outcome of every accepted request or release, and checks each outcome
// in order. Directed cases open the run. Random traffic then runs under
// several slot-count settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    import ssa_pkg::*;

    localparam int REG_STRIDE = 4;
    localparam int IDLE_PCT   = 38;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata;
    logic [0:0]            i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [15:0]           o_m_axis_tdata;
    logic [2:0]            o_m_axis_tuser;
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [APB_ADDR_W-1:0] i_paddr;
    logic [APB_DATA_W-1:0] i_pwdata;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    bit quiet;

    sized_slot_allocator_with_wait_queue_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    class slot_scoreboard;
        typedef struct {
            t_status           st;
            logic [SLOT_W-1:0] slot;
            logic [TAG_W-1:0]  tag;
        } t_outcome;

        logic [CNT_W-1:0]         count_reg [NUM_CLASSES];
        logic [DEF_MAX_SLOTS-1:0] busy      [NUM_CLASSES];
        logic [TAG_W-1:0]         waiters   [NUM_CLASSES][DEF_WAIT_DEPTH];
        int                       head      [NUM_CLASSES];
        int                       tail      [NUM_CLASSES];
        int                       fill      [NUM_CLASSES];
        t_outcome                 outcomes_q[$];
        int                       errors;

        function new();
            for (int c = 0; c < NUM_CLASSES; c++) begin
                count_reg[c] = '0;
                busy[c]      = '0;
                head[c]      = 0;
                tail[c]      = 0;
                fill[c]      = 0;
            end
            errors = 0;
        endfunction

        function void set_count(int c, logic [CNT_W-1:0] val);
            count_reg[c] = val;
        endfunction

        function int usable(int c);
            return (count_reg[c] > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : int'(count_reg[c]);
        endfunction

        function int first_id(int c);
            int b;
            b = 0;
            for (int k = 0; k < c; k++) b += usable(k);
            return b;
        endfunction

        function int pending();
            return outcomes_q.size();
        endfunction

        function void push(t_status st, int slot, logic [TAG_W-1:0] tag);
            t_outcome o;
            o.st   = st;
            o.slot = slot[SLOT_W-1:0];
            o.tag  = tag;
            outcomes_q.push_back(o);
        endfunction

        // id of a random occupied, reachable slot; -1 when none is held
        function int pick_busy_id();
            int ids[$];
            for (int c = 0; c < NUM_CLASSES; c++)
                for (int i = 0; i < usable(c); i++)
                    if (busy[c][i]) ids.push_back(first_id(c) + i);
            if (ids.size() == 0) return -1;
            return ids[$urandom_range(ids.size() - 1)];
        endfunction

        function void note_transfer(logic mode, logic [SIZE_W-1:0] size,
                                    logic [SLOT_W-1:0] id, logic [TAG_W-1:0] tag);
            int c, idx;
            if (mode == MODE_REQ) begin
                if (size < 1 || size > NUM_CLASSES) begin
                    push(ST_BAD, 0, '0);
                    return;
                end
                c = int'(size) - 1;
                for (int i = 0; i < usable(c); i++) begin
                    if (!busy[c][i]) begin
                        busy[c][i] = 1'b1;
                        push(ST_SEATED, first_id(c) + i, tag);
                        return;
                    end
                end
                if (fill[c] >= DEF_WAIT_DEPTH) begin
                    push(ST_FULL, 0, tag);
                    return;
                end
                waiters[c][tail[c]] = tag;
                tail[c] = (tail[c] + 1) % DEF_WAIT_DEPTH;
                fill[c]++;
                push(ST_WAITING, 0, tag);
            end else begin
                c   = 0;
                idx = int'(id);
                while (c < NUM_CLASSES && idx >= usable(c)) begin
                    idx -= usable(c);
                    c++;
                end
                if (c >= NUM_CLASSES || !busy[c][idx]) begin
                    push(ST_BAD, 0, '0);
                    return;
                end
                if (fill[c] > 0) begin
                    push(ST_HANDED, int'(id), waiters[c][head[c]]);
                    head[c] = (head[c] + 1) % DEF_WAIT_DEPTH;
                    fill[c]--;
                    return;
                end
                busy[c][idx] = 1'b0;
                push(ST_FREED, int'(id), '0);
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] slot,
                                   logic [TAG_W-1:0] tag);
            t_outcome o;
            if (outcomes_q.size() == 0) begin
                $error("unexpected result: status %0d slot %0d tag %0d", st, slot, tag);
                errors++;
                return;
            end
            o = outcomes_q.pop_front();
            if (st !== o.st) begin
                $error("status: expected %0d, got %0d", o.st, st);
                errors++;
            end
            if (slot !== o.slot) begin
                $error("granted_slot: expected %0d, got %0d", o.slot, slot);
                errors++;
            end
            if (tag !== o.tag) begin
                $error("granted_tag: expected %0d, got %0d", o.tag, tag);
                errors++;
            end
        endfunction
    endclass

    slot_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata[6:0], o_m_axis_tdata[14:7]);
    end

    task automatic send(logic mode, logic [SIZE_W-1:0] size, logic [SLOT_W-1:0] id,
                        logic [TAG_W-1:0] tag);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= {6'b0, tag, id, size};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_transfer(mode, size, id, tag);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [APB_DATA_W-1:0] val);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= APB_ADDR_W'(idx * REG_STRIDE);
        i_pwdata  <= val;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.set_count(idx, val[CNT_W-1:0]);
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic set_counts(int c1, int c2, int c3, int c4, int c5);
        wait_idle();
        apb_write(0, c1);
        apb_write(1, c2);
        apb_write(2, c3);
        apb_write(3, c4);
        apb_write(4, c5);
    endtask

    task automatic random_item();
        int               r, pick;
        logic [SIZE_W-1:0] sz;
        r = $urandom_range(99);
        if (r < 47) begin
            if ($urandom_range(19) == 0) begin
                case ($urandom_range(2))
                    0: sz = 3'd0;
                    1: sz = 3'd6;
                    default: sz = 3'd7;
                endcase
            end else begin
                sz = SIZE_W'($urandom_range(1, NUM_CLASSES));
            end
            send(MODE_REQ, sz, SLOT_W'($urandom_range(127)), TAG_W'($urandom_range(255)));
        end else if (r < 87) begin
            pick = sb.pick_busy_id();
            if (pick < 0) pick = int'($urandom_range(127));
            send(MODE_REL, SIZE_W'($urandom_range(7)), SLOT_W'(pick),
                 TAG_W'($urandom_range(255)));
        end else begin
            send(MODE_REL, SIZE_W'($urandom_range(7)), SLOT_W'($urandom_range(127)),
                 TAG_W'($urandom_range(255)));
        end
    endtask

    task automatic random_run(int n, int pause_at);
        for (int k = 0; k < n; k++) begin
            if (k == pause_at) wait_idle();
            random_item();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        i_psel          = 1'b0;
        i_penable       = 1'b0;
        i_pwrite        = 1'b0;
        i_paddr         = '0;
        i_pwdata        = '0;
        quiet           = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // class 1: id 0, class 2: none, class 3: 1..16, class 4: 17..18, class 5: 19..34
        set_counts(1, 0, 16, 2, 31);
        send(MODE_REQ, 3'd0, 7'd0,   8'h00);
        send(MODE_REQ, 3'd6, 7'd127, 8'hff);
        send(MODE_REQ, 3'd7, 7'd85,  8'h55);
        send(MODE_REQ, 3'd1, 7'd0,   8'h01);
        send(MODE_REQ, 3'd1, 7'd0,   8'h02);
        send(MODE_REQ, 3'd1, 7'd0,   8'h03);
        send(MODE_REL, 3'd7, 7'd0,   8'hff);
        send(MODE_REL, 3'd0, 7'd0,   8'h00);
        send(MODE_REL, 3'd1, 7'd0,   8'h00);
        send(MODE_REL, 3'd1, 7'd0,   8'h00);
        send(MODE_REL, 3'd1, 7'd127, 8'h00);
        send(MODE_REL, 3'd1, 7'd35,  8'h00);
        send(MODE_REQ, 3'd2, 7'd0,   8'haa);
        send(MODE_REQ, 3'd5, 7'd0,   8'hff);
        send(MODE_REL, 3'd5, 7'd19,  8'h00);
        send(MODE_REQ, 3'd4, 7'd0,   8'h10);
        send(MODE_REQ, 3'd4, 7'd0,   8'h11);
        send(MODE_REQ, 3'd4, 7'd0,   8'h12);
        send(MODE_REL, 3'd4, 7'd18,  8'h00);
        send(MODE_REL, 3'd4, 7'd34,  8'h00);
        send(MODE_REQ, 3'd3, 7'd0,   8'h80);
        send(MODE_REL, 3'd3, 7'd1,   8'h00);
        random_run(150, -1);

        // counts change with slots still held and waiters still queued
        set_counts(3, 1, 2, 4, 0);
        random_run(150, 75);

        set_counts(16, 16, 16, 16, 16);
        quiet = 1'b1;
        random_run(150, -1);
        quiet = 1'b0;

        set_counts(0, 0, 0, 0, 0);
        random_run(120, -1);

        set_counts(31, 31, 31, 31, 31);
        random_run(150, -1);

        for (int p = 0; p < 3; p++) begin
            set_counts($urandom_range(31), $urandom_range(31), $urandom_range(31),
                       $urandom_range(31), $urandom_range(31));
            random_run(110, -1);
        end

        set_counts(2, 1, 1, 3, 16);
        random_run(150, -1);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
